// File: sv/wrc_pkg.sv
`timescale 1ns / 1ps

package wrc_pkg;

  localparam int DEF_ADDR_BITS   = 8;
  localparam int DEF_NUM_RAMS    = 32;
  localparam int DEF_NUM_CLASSES = 4;
  localparam int DEF_COUNT_BITS  = 16;

  // Widest RAM position and tuple address any parameter setting can produce
  localparam int POS_MAX_W  = 8;
  localparam int ADDR_MAX_W = 16;

  localparam logic [15:0] THRESHOLD_RESET = 16'd0;
  localparam logic [5:0]  RAMS_RESET      = 6'd32;
  localparam logic [2:0]  CLASSES_RESET   = 3'd2;

  typedef enum logic [1:0] {
    OP_TRAIN = 2'd0,
    OP_TEST  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_RESPONSE  = 2'd0,
    STAT_TRAINED   = 2'd1,
    STAT_BAD_LABEL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_RAMS      = 2'd1,
    REG_CLASSES   = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_ACCESS,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    op_t                   op;
    logic [POS_MAX_W-1:0]  pos;
    logic [ADDR_MAX_W-1:0] addr;
    logic [1:0]            cls;
    logic                  bad;
    logic                  first;
    logic                  last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

endpackage

// File: sv/wrc_ram.sv
`timescale 1ns / 1ps

module wrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/wrc_front.sv
`timescale 1ns / 1ps

module wrc_front import wrc_pkg::*; #(
  parameter int ADDR_BITS   = DEF_ADDR_BITS,
  parameter int NUM_RAMS    = DEF_NUM_RAMS,
  parameter int NUM_CLASSES = DEF_NUM_CLASSES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [1:0]                         op,
  input  logic [1:0]                         class_label,
  input  logic [7:0]                         tuple_address,
  input  logic [$clog2(NUM_RAMS+1)-1:0]      nr,
  input  logic [$clog2(NUM_CLASSES+1)-1:0]   nc,
  input  back_stat_t                         bstat,
  output logic                               busy,
  output head_t                              head
);

  localparam int PW = (NUM_RAMS > 1) ? $clog2(NUM_RAMS) : 1;

  logic [PW-1:0] ram_position;
  logic [1:0]    pattern_class;
  logic          pattern_bad;
  item_t         q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  logic [PW-1:0] pos_cur;
  logic          first;
  logic          last;
  logic          label_bad;
  logic          accept;
  logic          push;
  logic          pop;
  item_t         item_in;

  always_comb begin
    pos_cur   = (32'(ram_position) >= 32'(nr)) ? '0 : ram_position;
    first     = (pos_cur == '0);
    last      = (32'(pos_cur) + 32'd1 >= 32'(nr));
    label_bad = (32'(class_label) >= 32'(nc));
    busy      = bstat.clearing || (fill == 2'd2);
    accept    = start && !busy;
    push      = accept && (op == OP_TRAIN || op == OP_TEST || op == OP_CLEAR);
    pop       = bstat.pop;

    item_in.op    = op_t'(op);
    item_in.pos   = POS_MAX_W'(pos_cur);
    item_in.addr  = ADDR_MAX_W'(ADDR_BITS'(tuple_address));
    item_in.cls   = first ? class_label : pattern_class;
    item_in.bad   = first ? label_bad : pattern_bad;
    item_in.first = first;
    item_in.last  = last;

    head.valid = (fill != 2'd0);
    head.item  = q[rd_ptr];
  end

  // Track the pattern position as items arrive
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_position  <= '0;
      pattern_class <= '0;
      pattern_bad   <= 1'b0;
    end else if (accept) begin
      case (op)
        OP_CLEAR: begin
          ram_position  <= '0;
          pattern_class <= '0;
          pattern_bad   <= 1'b0;
        end
        OP_TRAIN, OP_TEST: begin
          ram_position <= last ? '0 : PW'(32'(pos_cur) + 32'd1);
          if (first) begin
            pattern_class <= class_label;
            pattern_bad   <= label_bad;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= 2'(fill + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

// File: sv/wrc_back.sv
`timescale 1ns / 1ps

module wrc_back import wrc_pkg::*; #(
  parameter int ADDR_BITS   = DEF_ADDR_BITS,
  parameter int NUM_RAMS    = DEF_NUM_RAMS,
  parameter int NUM_CLASSES = DEF_NUM_CLASSES,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  head_t                            head,
  input  logic [15:0]                      thr,
  input  logic [$clog2(NUM_CLASSES+1)-1:0] nc,
  output back_stat_t                       bstat,
  output logic                             result_valid,
  output logic [1:0]                       status,
  output logic [1:0]                       class_index,
  output logic [5:0]                       hit_count,
  output logic [31:0]                      train_count,
  output logic [1:0]                       winner_class,
  output logic                             last_of_run
);

  localparam int PW     = (NUM_RAMS > 1) ? $clog2(NUM_RAMS) : 1;
  localparam int DEPTH  = NUM_RAMS * (2 ** ADDR_BITS);
  localparam int MEM_AW = $clog2(DEPTH);
  localparam int CW     = $clog2(NUM_CLASSES);
  localparam int TW     = $clog2(NUM_RAMS + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  back_state_t       state, state_next;
  logic [MEM_AW-1:0] sweep, sweep_next;
  item_t             cur;
  logic [TW-1:0]     tally [NUM_CLASSES];
  logic [TW-1:0]     tally_next [NUM_CLASSES];
  logic [31:0]       total [NUM_CLASSES];
  logic [31:0]       total_next [NUM_CLASSES];
  logic [CW-1:0]     emit_idx, emit_idx_next;
  logic [CW-1:0]     best_idx, best_idx_next;
  logic [TW-1:0]     best_val, best_val_next;

  logic              rv_next;
  logic [1:0]        status_next;
  logic [1:0]        class_next;
  logic [5:0]        hit_next;
  logic [31:0]       train_next;
  logic [1:0]        winner_next;
  logic              last_next;

  logic [COUNT_BITS-1:0] rd [NUM_CLASSES];
  logic [MEM_AW-1:0]     raddr;
  logic [MEM_AW-1:0]     waddr;
  logic                  clearing;
  logic                  pop;
  logic [CW-1:0]         cls_idx;
  logic [TW-1:0]         tv;
  logic                  take;
  logic                  fin;

  assign clearing = (state == BK_CLEAR);
  assign raddr    = MEM_AW'({head.item.pos[PW-1:0], head.item.addr[ADDR_BITS-1:0]});
  assign waddr    = clearing ? sweep : MEM_AW'({cur.pos[PW-1:0], cur.addr[ADDR_BITS-1:0]});
  assign cls_idx  = CW'(cur.cls);
  assign bstat.clearing = clearing;
  assign bstat.pop      = pop;

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_bank
    logic                  we;
    logic [COUNT_BITS-1:0] wdata;

    assign we = clearing ||
                (state == BK_ACCESS && cur.op == OP_TRAIN && !cur.bad &&
                 32'(cur.cls) == g && rd[g] != CMAX);
    assign wdata = clearing ? '0 : COUNT_BITS'(rd[g] + 1'b1);

    wrc_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
      sweep <= '0;
    end else begin
      state <= state_next;
      sweep <= sweep_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        tally[c] <= '0;
        total[c] <= '0;
      end
      result_valid <= 1'b0;
    end else begin
      tally        <= tally_next;
      total        <= total_next;
      result_valid <= rv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.item;
    end
    emit_idx     <= emit_idx_next;
    best_idx     <= best_idx_next;
    best_val     <= best_val_next;
    status       <= status_next;
    class_index  <= class_next;
    hit_count    <= hit_next;
    train_count  <= train_next;
    winner_class <= winner_next;
    last_of_run  <= last_next;
  end

  always_comb begin
    state_next    = state;
    sweep_next    = sweep;
    tally_next    = tally;
    total_next    = total;
    emit_idx_next = emit_idx;
    best_idx_next = best_idx;
    best_val_next = best_val;
    pop           = 1'b0;
    rv_next       = 1'b0;
    status_next   = STAT_RESPONSE;
    class_next    = '0;
    hit_next      = '0;
    train_next    = '0;
    winner_next   = '0;
    last_next     = 1'b0;
    tv            = tally[emit_idx];
    take          = (emit_idx == '0) || (tv > best_val);
    fin           = (32'(emit_idx) + 32'd1 == 32'(nc));

    case (state)
      BK_CLEAR: begin
        sweep_next = MEM_AW'(sweep + 1'b1);
        for (int c = 0; c < NUM_CLASSES; c++) begin
          tally_next[c] = '0;
          total_next[c] = '0;
        end
        if (sweep == MEM_AW'(DEPTH - 1)) begin
          sweep_next = '0;
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = (head.item.op == OP_CLEAR) ? BK_CLEAR : BK_ACCESS;
          sweep_next = '0;
        end
      end
      BK_ACCESS: begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          tally_next[c] = TW'((cur.first ? '0 : tally[c]) +
                          ((cur.op == OP_TEST && c < 32'(nc) &&
                            32'(rd[c]) > 32'(thr)) ? 1'b1 : 1'b0));
        end
        state_next = BK_IDLE;
        if (cur.op == OP_TRAIN) begin
          if (cur.last) begin
            rv_next    = 1'b1;
            class_next = cur.cls;
            last_next  = 1'b1;
            if (cur.bad) begin
              status_next = STAT_BAD_LABEL;
            end else begin
              // Hold the total at all ones once saturated
              if (total[cls_idx] != '1) begin
                total_next[cls_idx] = total[cls_idx] + 32'd1;
              end
              status_next = STAT_TRAINED;
              train_next  = total_next[cls_idx];
            end
          end
        end else if (cur.last) begin
          emit_idx_next = '0;
          state_next    = BK_EMIT;
        end
      end
      BK_EMIT: begin
        rv_next       = 1'b1;
        status_next   = STAT_RESPONSE;
        class_next    = 2'(emit_idx);
        hit_next      = 6'(tv);
        train_next    = total[emit_idx];
        best_idx_next = take ? emit_idx : best_idx;
        best_val_next = take ? tv : best_val;
        winner_next   = fin ? 2'(best_idx_next) : 2'd0;
        last_next     = fin;
        emit_idx_next = CW'(emit_idx + 1'b1);
        if (fin) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

endmodule

// File: sv/weightless_ram_classifier_unit.sv
`timescale 1ns / 1ps

// WiSARD discriminator bank. Drive start with one tuple address per item, in
// RAM order; an item is taken when start is high and busy is low. A two-entry
// queue sits in front of the counter memories, so start is taken while the
// previous item is still at work. Each train or test item passes the memory
// side in two steps (registered read of every class bank, then the counter
// update or threshold tally); the next item leaves the queue only after that
// update. The last test item of a pattern then emits one result per class in
// use. After reset and after every clear item, a clearing pass writes zero to
// all NUM_RAMS * 2**ADDR_BITS locations of every bank in parallel, with busy
// high. Results appear for exactly one cycle under result_valid and cannot be
// held off by the receiver.
module weightless_ram_classifier_unit import wrc_pkg::*; #(
  parameter int ADDR_BITS   = DEF_ADDR_BITS,
  parameter int NUM_RAMS    = DEF_NUM_RAMS,
  parameter int NUM_CLASSES = DEF_NUM_CLASSES,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [1:0]  class_label,
  input  logic [7:0]  tuple_address,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [1:0]  class_index,
  output logic [5:0]  hit_count,
  output logic [31:0] train_count,
  output logic [1:0]  winner_class,
  output logic        last_of_run
);

  localparam int RW  = $clog2(NUM_RAMS + 1);
  localparam int CNW = $clog2(NUM_CLASSES + 1);

  logic [15:0]    hit_threshold;
  logic [5:0]     rams_in_use;
  logic [2:0]     classes_in_use;
  logic [RW-1:0]  nr;
  logic [CNW-1:0] nc;
  head_t          head;
  back_stat_t     bstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_threshold  <= THRESHOLD_RESET;
      rams_in_use    <= RAMS_RESET;
      classes_in_use <= CLASSES_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD: hit_threshold  <= cfg_data;
        REG_RAMS:      rams_in_use    <= cfg_data[5:0];
        REG_CLASSES:   classes_in_use <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp register values into the ranges the hardware supports
  always_comb begin
    if (rams_in_use == '0) begin
      nr = RW'(1);
    end else if (32'(rams_in_use) > NUM_RAMS) begin
      nr = RW'(NUM_RAMS);
    end else begin
      nr = RW'(rams_in_use);
    end
    if (classes_in_use == '0) begin
      nc = CNW'(1);
    end else if (32'(classes_in_use) > NUM_CLASSES) begin
      nc = CNW'(NUM_CLASSES);
    end else begin
      nc = CNW'(classes_in_use);
    end
  end

  wrc_front #(
    .ADDR_BITS  (ADDR_BITS),
    .NUM_RAMS   (NUM_RAMS),
    .NUM_CLASSES(NUM_CLASSES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .op           (op),
    .class_label  (class_label),
    .tuple_address(tuple_address),
    .nr           (nr),
    .nc           (nc),
    .bstat        (bstat),
    .busy         (busy),
    .head         (head)
  );

  wrc_back #(
    .ADDR_BITS  (ADDR_BITS),
    .NUM_RAMS   (NUM_RAMS),
    .NUM_CLASSES(NUM_CLASSES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .thr         (hit_threshold),
    .nc          (nc),
    .bstat       (bstat),
    .result_valid(result_valid),
    .status      (status),
    .class_index (class_index),
    .hit_count   (hit_count),
    .train_count (train_count),
    .winner_class(winner_class),
    .last_of_run (last_of_run)
  );

`ifndef SYNTHESIS
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !bstat.clearing)
    else $error("result emitted during clearing pass");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_run |=> !result_valid)
    else $error("result directly follows the last result of a run");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_run |=> result_valid)
    else $error("class result run broken off");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import wrc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 40000;
  localparam int SETTLE = 20;
  // Random items on top of the directed ones, about 260 in all
  localparam int RANDOM_ITEMS = 175;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] label;
    logic [7:0] addr;
  } stim_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  cls;
    logic [5:0]  hits;
    logic [31:0] trains;
    logic [1:0]  winner;
    logic        last;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] op = '0;
  logic [1:0] class_label = '0;
  logic [7:0] tuple_address = '0;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic result_valid;
  logic [1:0] status;
  logic [1:0] class_index;
  logic [5:0] hit_count;
  logic [31:0] train_count;
  logic [1:0] winner_class;
  logic last_of_run;

  weightless_ram_classifier_unit DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the discriminator bank
  logic [15:0] loc_count [logic [14:0]];
  logic [31:0] train_total [4];
  logic [5:0]  hit_tally [4];
  int          ram_pos;
  logic [1:0]  pat_class;
  logic        pat_bad;
  logic [15:0] threshold = THRESHOLD_RESET;
  logic [5:0]  rams_reg = RAMS_RESET;
  logic [2:0]  classes_reg = CLASSES_RESET;

  stim_t    pending [$];
  verdict_t verdicts [$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic logic [15:0] count_at(int c, int p, logic [7:0] a);
    logic [14:0] key;
    key = {c[1:0], p[4:0], a};
    return loc_count.exists(key) ? loc_count[key] : 16'd0;
  endfunction

  function automatic void wipe_bank();
    loc_count.delete();
    for (int c = 0; c < 4; c++) begin
      train_total[c] = '0;
      hit_tally[c] = '0;
    end
    ram_pos = 0;
    pat_class = '0;
    pat_bad = 1'b0;
  endfunction

  function automatic void classify(stim_t s);
    int nr, nc, p, win;
    logic lastp;
    logic [14:0] key;
    verdict_t v;
    nr = (rams_reg == 0) ? 1 : (rams_reg > 32) ? 32 : rams_reg;
    nc = (classes_reg == 0) ? 1 : (classes_reg > 4) ? 4 : classes_reg;
    if (s.op == OP_CLEAR) begin
      wipe_bank();
      return;
    end
    if (s.op == OP_UNUSED) return;
    if (ram_pos >= nr) ram_pos = 0;
    p = ram_pos;
    if (p == 0) begin
      pat_class = s.label;
      pat_bad = (s.label >= nc);
      for (int c = 0; c < 4; c++) hit_tally[c] = '0;
    end
    lastp = (p + 1 >= nr);
    ram_pos = lastp ? 0 : p + 1;
    if (s.op == OP_TRAIN) begin
      if (!pat_bad) begin
        key = {pat_class, p[4:0], s.addr};
        if (count_at(pat_class, p, s.addr) != 16'hFFFF)
          loc_count[key] = count_at(pat_class, p, s.addr) + 16'd1;
      end
      if (!lastp) return;
      v = '0;
      v.cls = pat_class;
      v.last = 1'b1;
      if (pat_bad) begin
        v.status = STAT_BAD_LABEL;
      end else begin
        if (train_total[pat_class] != 32'hFFFF_FFFF)
          train_total[pat_class] += 1;
        v.status = STAT_TRAINED;
        v.trains = train_total[pat_class];
      end
      verdicts.push_back(v);
      return;
    end
    for (int c = 0; c < nc; c++)
      if (count_at(c, p, s.addr) > threshold) hit_tally[c] += 1;
    if (!lastp) return;
    win = 0;
    for (int c = 1; c < nc; c++)
      if (hit_tally[c] > hit_tally[win]) win = c;
    for (int c = 0; c < nc; c++) begin
      v.status = STAT_RESPONSE;
      v.cls = c[1:0];
      v.hits = hit_tally[c];
      v.trains = train_total[c];
      v.last = (c + 1 == nc);
      v.winner = v.last ? win[1:0] : 2'd0;
      verdicts.push_back(v);
    end
  endfunction

  // Driver: bursts of items with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    stim_t s;
    logic taken, drive;
    if (!rst) begin
      taken = start && !busy;
      if (taken) classify('{op, class_label, tuple_address});
      drive = start && !taken;
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          s = pending.pop_front();
          op <= s.op;
          class_label <= s.label;
          tuple_address <= s.addr;
          drive = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
      start <= drive;
    end
  end

  // Monitor and watchdog
  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst) begin
      if ((start && !busy) || result_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
      if (result_valid) begin
        got = '{status_t'(status), class_index, hit_count, train_count, winner_class,
                last_of_run};
        if (verdicts.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          want = verdicts.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  task automatic put(logic [1:0] o, logic [1:0] l, logic [7:0] a);
    pending.push_back('{o, l, a});
  endtask

  task automatic drain();
    wait (pending.size() == 0 && !start && verdicts.size() == 0 && !busy);
    repeat (SETTLE) @(posedge clk);
    wait (!busy);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_THRESHOLD: threshold = val;
      REG_RAMS:      rams_reg = val[5:0];
      default:       classes_reg = val[2:0];
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic setup(logic [15:0] thr, logic [5:0] nr, logic [2:0] nc);
    drain();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_RAMS, {10'd0, nr});
    write_reg(REG_CLASSES, {13'd0, nc});
  endtask

  initial begin
    int nr, nc, sent, kind;
    logic [1:0] lbl;
    wipe_bank();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: two-RAM patterns, all four classes
    setup(16'd0, 6'd2, 3'd4);
    put(OP_TRAIN, 2'd0, 8'h00); put(OP_TRAIN, 2'd0, 8'hFF);
    put(OP_TRAIN, 2'd3, 8'h00); put(OP_TRAIN, 2'd1, 8'hAA);
    put(OP_TEST, 2'd2, 8'h00);  put(OP_TEST, 2'd0, 8'hFF);
    put(OP_TEST, 2'd0, 8'h55);  put(OP_TEST, 2'd0, 8'h00);
    // mixed ops in one pattern, then an unused op
    put(OP_TRAIN, 2'd1, 8'h55); put(OP_TEST, 2'd3, 8'h00);
    put(OP_UNUSED, 2'd3, 8'hFF);
    put(OP_TEST, 2'd1, 8'h33);  put(OP_TRAIN, 2'd0, 8'hFF);
    put(OP_CLEAR, 2'd2, 8'h12);
    put(OP_TEST, 2'd0, 8'h00);  put(OP_TEST, 2'd0, 8'hFF);
    // bad label with three classes
    setup(16'd0, 6'd2, 3'd3);
    put(OP_TRAIN, 2'd3, 8'h01); put(OP_TRAIN, 2'd0, 8'h02);
    put(OP_TEST, 2'd3, 8'h01);  put(OP_TEST, 2'd0, 8'h02);
    // out-of-range registers: zero acts as one, large values clamp
    setup(16'd65535, 6'd0, 3'd0);
    put(OP_TRAIN, 2'd0, 8'h07); put(OP_TRAIN, 2'd1, 8'h07); put(OP_TEST, 2'd0, 8'h07);
    setup(16'd0, 6'd63, 3'd7);
    for (int i = 0; i < 32; i++) put(OP_TRAIN, 2'd2, i[7:0]);
    for (int i = 0; i < 32; i++) put(OP_TEST, 2'd0, i[7:0]);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: nr = 32;
        1: nr = 1;
        default: nr = $urandom_range(2, 6);
      endcase
      nc = $urandom_range(1, 4);
      setup(($urandom_range(0, 3) == 0) ? 16'd65535 : 16'($urandom_range(0, 2)),
            6'(nr), 3'(nc));
      for (int k = 0; k < 6 && sent < RANDOM_ITEMS; k++) begin
        kind = $urandom_range(0, 19);
        lbl = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'($urandom_range(0, nc - 1));
        for (int i = 0; i < nr; i++) begin
          if (kind == 0 && i == nr - 1) put(OP_UNUSED, 2'($urandom), 8'($urandom));
          if (kind == 1) put(2'($urandom_range(0, 1)), lbl, 8'($urandom));
          else put((kind < 11) ? OP_TRAIN : OP_TEST, lbl,
                   ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
          sent++;
        end
      end
      if ($urandom_range(0, 9) == 0) put(OP_CLEAR, 2'($urandom), 8'($urandom));
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
